// ===== hdl/pros_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the paired read overlap search
// no dependencies

package pros_pkg;

  localparam int MaxLenDef = 256;
  localparam int WindowDef = 50;
  localparam int CfgIdxW = 2;
  localparam int QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] CfgDiffLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOverlapReq = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDiffFrac = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COMPARE,
    ST_CHECK,
    ST_NEXT,
    ST_DONE
  } search_state_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic       op;
    logic [7:0] base;
    logic       last;
  } item_t;

  function automatic logic [7:0] complement_base(input logic [7:0] b);
    logic [7:0] r;
    begin
      case (b)
        8'h41, 8'h61: r = 8'h54;
        8'h54, 8'h74: r = 8'h41;
        8'h43, 8'h63: r = 8'h47;
        8'h47, 8'h67: r = 8'h43;
        default:      r = 8'h4E;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/pros_front.sv =====
`timescale 1ns / 1ps
// front end: accepts base transactions into a short queue
// depends on pros_pkg

module pros_front
  import pros_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_start,
  input  logic  in_op,
  input  logic  [7:0] in_base,
  input  logic  in_last,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int PtrW = $clog2(QueueDepth);

  item_t            mem [QueueDepth];
  logic [PtrW-1:0]  wr_r, rd_r;
  logic [PtrW:0]    cnt_r;
  logic             push;

  assign full    = (cnt_r == (PtrW+1)'(QueueDepth));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem[rd_r];
  assign push    = in_start && !full;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= '{op: in_op, base: in_base, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PtrW'(1);
      if (pop)  rd_r <= rd_r + PtrW'(1);
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== hdl/pros_back.sv =====
`timescale 1ns / 1ps
// back end: read stores, shift search with mismatch counting, result register
// depends on pros_pkg

module pros_back
  import pros_pkg::*;
#(
  parameter int MaxLen = MaxLenDef,
  parameter int Window = WindowDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        idle,
  input  logic [8:0]  diff_limit,
  input  logic [8:0]  overlap_require,
  input  logic [15:0] diff_fraction_q16,
  output logic        out_valid,
  output logic        out_overlapped,
  output logic signed [9:0] out_offset,
  output logic [8:0]  out_ovl_bases,
  output logic [8:0]  out_mismatches,
  output logic        out_too_long
);

  localparam int AW = $clog2(MaxLen);
  localparam int LW = AW + 1;
  localparam int WW = $clog2(Window + 1);

  logic [7:0] s1 [MaxLen];
  logic [7:0] s2 [MaxLen];
  logic [7:0] rd1_r, rd2_r;

  logic [LW-1:0] len1_r, len2_r, k_r, lim_r, ol_r, idx_r, n_r;
  logic          ovf_r, dir_r, cmp_v_r;
  logic [8:0]    d_r;
  logic [LW+15:0] prod_r;
  search_state_t st_r, st_nxt;

  logic [AW-1:0] a1, a2;
  logic [LW-1:0] ola, olb;
  logic          load;

  assign idle = (st_r == ST_IDLE) && !q_valid;
  assign load = (st_r == ST_IDLE) && q_valid;
  assign pop  = load;

  // overlap at the current shift
  always_comb begin
    ola = dir_r ? len2_r - k_r : len1_r - k_r;
    olb = dir_r ? len1_r : len2_r;
  end

  // s2 holds complemented bases, so rc2[i] = s2[len2-1-i]
  always_comb begin
    if (!dir_r) begin
      a1 = AW'(k_r + idx_r);
      a2 = AW'(len2_r - LW'(1) - idx_r);
    end else begin
      a1 = AW'(idx_r);
      a2 = AW'(len2_r - LW'(1) - k_r - idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_item.op && len1_r < LW'(MaxLen)) s1[AW'(len1_r)] <= q_item.base;
    if (load && q_item.op && len2_r < LW'(MaxLen)) begin
      s2[AW'(len2_r)] <= complement_base(q_item.base);
    end
    rd1_r <= s1[a1];
    rd2_r <= s2[a2];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:    if (load && q_item.op && q_item.last) st_nxt = ST_SETUP;
      ST_SETUP:   st_nxt = ST_NEXT;
      ST_NEXT:    st_nxt = ST_COMPARE;
      ST_COMPARE: if (idx_r == n_r && !cmp_v_r) st_nxt = ST_CHECK;
      ST_CHECK:   st_nxt = ST_NEXT;
      ST_DONE:    st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  logic [8:0] frac;
  logic [8:0] allowed;
  always_comb begin
    frac    = 9'(prod_r >> 16);
    allowed = (frac < diff_limit) ? frac : diff_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; len1_r <= '0; len2_r <= '0; ovf_r <= 1'b0;
      out_valid <= 1'b0; cmp_v_r <= 1'b0; dir_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (load) begin
            if (!q_item.op) begin
              if (len1_r < LW'(MaxLen)) len1_r <= len1_r + LW'(1);
              else ovf_r <= 1'b1;
            end else begin
              if (len2_r < LW'(MaxLen)) len2_r <= len2_r + LW'(1);
              else ovf_r <= 1'b1;
            end
          end
          st_r <= st_nxt;
        end
        ST_SETUP: begin
          dir_r <= 1'b0;
          k_r   <= '0;
          lim_r <= (10'(overlap_require) < 10'(len1_r)) ?
                   LW'(10'(len1_r) - 10'(overlap_require)) : '0;
          st_r  <= st_nxt;
        end
        ST_NEXT: begin
          if (k_r >= lim_r) begin
            if (!dir_r) begin
              dir_r <= 1'b1;
              k_r   <= '0;
              lim_r <= (10'(overlap_require) < 10'(len2_r)) ?
                       LW'(10'(len2_r) - 10'(overlap_require)) : '0;
            end else begin
              out_valid <= 1'b1; out_overlapped <= 1'b0; out_offset <= '0;
              out_ovl_bases <= '0; out_mismatches <= '0; out_too_long <= ovf_r;
              len1_r <= '0; len2_r <= '0; ovf_r <= 1'b0;
              st_r <= ST_IDLE;
            end
          end else begin
            ol_r   <= (ola < olb) ? ola : olb;
            n_r    <= (((ola < olb) ? ola : olb) < LW'(Window)) ?
                      ((ola < olb) ? ola : olb) : LW'(Window);
            prod_r <= (LW+16)'(((ola < olb) ? ola : olb)) * (LW+16)'(diff_fraction_q16);
            idx_r  <= '0; d_r <= '0; cmp_v_r <= 1'b0;
            st_r   <= st_nxt;
          end
        end
        ST_COMPARE: begin
          // memory reads are registered: compare the pair fetched last cycle
          if (cmp_v_r && rd1_r != rd2_r) d_r <= d_r + 9'd1;
          cmp_v_r <= (idx_r != n_r);
          if (idx_r != n_r) idx_r <= idx_r + LW'(1);
          st_r <= st_nxt;
        end
        ST_CHECK: begin
          if (d_r <= allowed) begin
            out_valid <= 1'b1; out_overlapped <= 1'b1;
            out_offset <= dir_r ? -$signed(10'(k_r)) : $signed(10'(k_r));
            out_ovl_bases <= 9'(ol_r); out_mismatches <= d_r; out_too_long <= ovf_r;
            len1_r <= '0; len2_r <= '0; ovf_r <= 1'b0;
            st_r <= ST_IDLE;
          end else begin
            k_r  <= k_r + LW'(1);
            st_r <= st_nxt;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/paired_read_overlap_search.sv =====
`timescale 1ns / 1ps
// Paired read overlap search. Bases are queued at one per cycle (busy rises when the
// four-entry queue fills). A read-two base with in_last starts the shift search, which
// runs in the back end, forward then backward; bases keep queuing meanwhile until the
// queue fills. One result strobes on out_valid per pair; it cannot be stalled. Register
// writes are taken (cfg_ready) only while the back end is idle and the queue is empty.
// depends on pros_pkg, pros_front, pros_back

module paired_read_overlap_search
  import pros_pkg::*;
#(
  parameter int MaxLen = MaxLenDef,
  parameter int Window = WindowDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_base,
  input  logic        in_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic        out_overlapped,
  output logic signed [9:0] out_offset,
  output logic [8:0]  out_ovl_bases,
  output logic [8:0]  out_mismatches,
  output logic        out_too_long
);

  logic [8:0]  diff_limit_r, overlap_require_r;
  logic [15:0] diff_fraction_r;
  logic        full, pop, q_valid, idle;
  item_t       q_item;

  assign busy      = full;
  assign cfg_ready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_limit_r      <= 9'd5;
      overlap_require_r <= 9'd30;
      diff_fraction_r   <= 16'd13107;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgDiffLimit:  diff_limit_r      <= cfg_data[8:0];
        CfgOverlapReq: overlap_require_r <= cfg_data[8:0];
        CfgDiffFrac:   diff_fraction_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  pros_front u_front (
    .clk, .rst_n, .in_start(start), .in_op, .in_base, .in_last,
    .full, .pop, .q_valid, .q_item
  );

  pros_back #(.MaxLen(MaxLen), .Window(Window)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop, .idle,
    .diff_limit(diff_limit_r), .overlap_require(overlap_require_r),
    .diff_fraction_q16(diff_fraction_r),
    .out_valid, .out_overlapped, .out_offset, .out_ovl_bases,
    .out_mismatches, .out_too_long
  );

endmodule
